### src/der_tlv_parser_top_macros.svh
// assertion macros for the der tlv parser checker
`ifndef DER_TLV_PARSER_TOP_MACROS_SVH
`define DER_TLV_PARSER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DTLV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtlv check failed");

// next-cycle implication, sampled on clk, off during reset
`define DTLV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtlv check failed");

`endif

### src/dtlv_pkg.sv
// types and codes for the der tlv parser
package dtlv_pkg;

    localparam logic [1:0] PH_TAG  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_LONG = 2'd2;
    localparam logic [1:0] PH_VAL  = 2'd3;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TRUNC_LEN = 2'd1;
    localparam logic [1:0] ERR_TRUNC_VAL = 2'd2;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd3;

    localparam logic [7:0] LONG_FORM_BIT = 8'h80;
    localparam logic [7:0] COUNT_MASK    = 8'h7F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in_buffer;
    } in_t;

    typedef struct packed {
        logic [31:0] value_index;
        logic [7:0]  value_byte;
        logic [31:0] length;
        logic [7:0]  tag;
        logic        element_done;
        logic [1:0]  error_code;
        logic [1:0]  kind;
    } res_t;

endpackage

### src/dtlv_core.sv
// parse state and per-byte next-state logic of the der tlv parser
module dtlv_core
    import dtlv_pkg::*;
#(
    parameter int LEN_BYTES = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  in_t  item,
    output logic emit,
    output res_t res
);

    localparam int CW = $clog2(LEN_BYTES + 1);

    logic [1:0]    phase_reg,  phase_next;
    logic [7:0]    tag_reg,    tag_next;
    logic [CW-1:0] left_reg,   left_next;
    logic [31:0]   accum_reg,  accum_next;
    logic [31:0]   remain_reg, remain_next;
    logic [31:0]   offset_reg, offset_next;

    logic [6:0]    count;
    logic [CW-1:0] left_dec;
    logic          do_hdr;
    logic [7:0]    b;
    logic          last;

    assign b     = item.in_byte;
    assign last  = item.last_in_buffer;
    assign count = 7'(b & COUNT_MASK);
    assign left_dec = left_reg - CW'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        accum_next  = accum_reg;
        remain_next = remain_reg;
        offset_next = offset_reg;
        do_hdr      = 1'b0;
        emit        = 1'b0;
        res         = '0;

        unique case (phase_reg)
            PH_TAG:
            begin
                tag_next   = b;
                accum_next = '0;
                if (last)
                begin
                    emit           = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNC_LEN;
                    phase_next     = PH_TAG;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if ((b & LONG_FORM_BIT) == 8'h00)
                begin
                    accum_next = {24'h0, b};
                    do_hdr     = 1'b1;
                end
                else if (count > 7'(LEN_BYTES))
                begin
                    emit           = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TOO_LARGE;
                    phase_next     = PH_TAG;
                end
                else
                begin
                    accum_next = '0;
                    if (count == 7'd0)
                    begin
                        do_hdr = 1'b1;
                    end
                    else if (last)
                    begin
                        emit           = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_TRUNC_LEN;
                        phase_next     = PH_TAG;
                    end
                    else
                    begin
                        left_next  = count[CW-1:0];
                        phase_next = PH_LONG;
                    end
                end
            end
            PH_LONG:
            begin
                // big-endian length bytes, only the low 32 bits are kept
                accum_next = {accum_reg[23:0], b};
                left_next  = left_dec;
                if (left_dec == '0)
                begin
                    do_hdr = 1'b1;
                end
                else if (last)
                begin
                    emit           = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TRUNC_LEN;
                    phase_next     = PH_TAG;
                end
            end
            PH_VAL:
            begin
                remain_next     = remain_reg - 32'd1;
                offset_next     = offset_reg + 32'd1;
                emit            = 1'b1;
                res.kind        = KIND_VALUE;
                res.length      = accum_reg;
                res.value_byte  = b;
                res.value_index = offset_reg;
                if (remain_next == 32'd0)
                begin
                    res.element_done = 1'b1;
                    phase_next       = PH_TAG;
                end
                else if (last)
                begin
                    res.error_code = ERR_TRUNC_VAL;
                    phase_next     = PH_TAG;
                end
            end
            default:
            begin
                phase_next = PH_TAG;
            end
        endcase

        if (do_hdr)
        begin
            remain_next = accum_next;
            offset_next = '0;
            emit        = 1'b1;
            res.kind    = KIND_HEADER;
            if (accum_next == 32'd0)
            begin
                res.element_done = 1'b1;
                phase_next       = PH_TAG;
            end
            else
            begin
                res.length = accum_next;
                if (last)
                begin
                    res.error_code = ERR_TRUNC_VAL;
                    phase_next     = PH_TAG;
                end
                else
                begin
                    phase_next = PH_VAL;
                end
            end
        end

        res.tag = tag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            tag_reg    <= '0;
            left_reg   <= '0;
            accum_reg  <= '0;
            remain_reg <= '0;
            offset_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            left_reg   <= left_next;
            accum_reg  <= accum_next;
            remain_reg <= remain_next;
            offset_reg <= offset_next;
        end
    end

endmodule

### src/der_tlv_parser_top.sv
// Streaming DER tag-length-value parser, one encoded byte per transaction on
// the slave side. Each byte is latched in an input register, runs through the
// phase logic once, and any result lands in an output register backed by a
// one-entry skid stage. One byte is taken every cycle while results drain;
// a result goes from the input register to the output register, or to the
// skid entry while the output is held. Tag and length bytes give no result
// except on errors; a header result comes with the last length byte and each
// value byte gives one result. After an error the next byte is read as a new tag.
module der_tlv_parser_top
    import dtlv_pkg::*;
#(
    parameter int LEN_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // last_in_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // tag, length, value_byte, value_index
    output logic        m_axis_tlast,   // element_done
    output logic [3:0]  m_axis_tuser    // kind, error_code
);

    logic in_valid_reg;
    in_t  in_reg;
    logic fire;
    logic emit;
    res_t res;

    logic out_valid_reg;
    res_t out_reg;
    logic skid_valid_reg;
    res_t skid_reg;

    assign fire          = in_valid_reg && !skid_valid_reg;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.in_byte        <= s_axis_tdata;
            in_reg.last_in_buffer <= s_axis_tlast;
        end
    end

    dtlv_core #(
        .LEN_BYTES (LEN_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_reg),
        .emit  (emit),
        .res   (res)
    );

    // output register with skid entry, a push only happens while the skid is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fire && emit;
            end
        end
        else if (fire && emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (fire && emit)
            begin
                out_reg <= res;
            end
        end
        else if (fire && emit)
        begin
            skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.value_index, out_reg.value_byte,
                            out_reg.length, out_reg.tag};
    assign m_axis_tlast  = out_reg.element_done;
    assign m_axis_tuser  = {out_reg.error_code, out_reg.kind};

endmodule

### src/dtlv_checker.sv
// port-level checks for the der tlv parser and their bind
`include "der_tlv_parser_top_macros.svh"

module dtlv_checker
    import dtlv_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [3:0]  m_axis_tuser
);

    logic [1:0]  kind;
    logic [1:0]  err;
    logic [31:0] len;
    logic        in_hs;

    assign kind  = m_axis_tuser[1:0];
    assign err   = m_axis_tuser[3:2];
    assign len   = m_axis_tdata[39:8];
    assign in_hs = s_axis_tvalid && s_axis_tready && s_axis_tdata[7] && s_axis_tlast;

    `DTLV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `DTLV_ASSERT_NOW(a_kind_legal, m_axis_tvalid, kind != 2'd3)
    `DTLV_ASSERT_NOW(a_error_only, m_axis_tvalid && kind == KIND_ERROR,
        len == 32'd0 && !m_axis_tlast && err != ERR_NONE && err != ERR_TRUNC_VAL)
    `DTLV_ASSERT_NOW(a_done_clean, m_axis_tvalid && m_axis_tlast,
        err == ERR_NONE && kind != KIND_ERROR)
    `DTLV_ASSERT_NOW(a_empty_header, m_axis_tvalid && kind == KIND_HEADER && m_axis_tlast,
        len == 32'd0 && !in_hs || len == 32'd0)

endmodule

bind der_tlv_parser_top dtlv_checker u_dtlv_checker (.*);
